// File: rtl/mami_pkg.sv
`timescale 1ns / 1ps
package mami_pkg;
    localparam int MAX_DIM = 8;
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int DIM_W = 4;
    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0]        cmd;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              is_identity;
        logic              last;
    } t_result;
endpackage

// File: rtl/mami_front.sv
`timescale 1ns / 1ps
// Accepts items, drops cmd 3, and queues the rest for the back end.
module mami_front import mami_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_take,
    output t_item o_item
);
    t_item              r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [QPTR_W:0]    r_cnt;
    logic               w_acc, w_keep, w_take;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign w_acc   = i_push && !o_full;
    assign w_keep  = w_acc && (i_item.cmd == CMD_LOAD_A || i_item.cmd == CMD_LOAD_B
                              || i_item.cmd == CMD_COMPUTE);
    assign o_valid = (r_cnt != '0);
    assign w_take  = i_take && o_valid;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_keep) r_q[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_keep) r_wp <= r_wp + 1'b1;
            if (w_take) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(w_keep) - (QPTR_W+1)'(w_take);
        end
    end
endmodule

// File: rtl/mami_back.sv
`timescale 1ns / 1ps
// Executes loads and computes. One shared MAC, one memory read pair per MAC step.
module mami_back import mami_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DIM_W-1:0] i_dim,
    input  logic             i_mode,
    input  logic             i_valid,
    output logic             o_take,
    input  t_item            i_item,
    output logic             o_empty,
    input  logic             i_pop,
    output t_result          o_res
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_ACC  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [DATA_W-1:0]   r_mem_a [DEPTH];
    logic [DATA_W-1:0]   r_mem_b [DEPTH];
    logic [DATA_W-1:0]   r_rd_a, r_rd_b, r_acc;
    logic [IDX_W-1:0]    r_r, r_c, r_k, r_n1;
    logic                r_mul, r_id, r_lastk;
    logic                r_ovalid;
    t_result             r_out;
    logic [DIM_W-1:0]    w_n;
    logic [ADDR_W-1:0]   w_aa, w_ba;
    logic                w_issue, w_kend, w_elem_last, w_out_free;
    logic [DATA_W-1:0]   w_sum, w_want;

    always_comb begin
        if (i_dim == '0) w_n = DIM_W'(1);
        else if (i_dim > DIM_W'(MAX_DIM)) w_n = DIM_W'(MAX_DIM);
        else w_n = i_dim;
    end

    assign w_out_free = !r_ovalid || i_pop;
    assign o_take  = (r_state == S_IDLE) && i_valid;
    assign w_issue = (r_state == S_RUN);
    assign w_kend  = !r_mul || (r_k == r_n1);
    assign w_aa = r_mul ? {r_r, r_k} : {r_r, r_c};
    assign w_ba = r_mul ? {r_k, r_c} : {r_r, r_c};
    assign w_sum = r_mul ? r_acc + r_rd_a * r_rd_b : r_rd_a + r_rd_b;
    assign w_want = (r_r == r_c) ? DATA_W'(1) : '0;
    assign w_elem_last = (r_r == r_n1) && (r_c == r_n1);

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.cmd == CMD_LOAD_A) r_mem_a[{i_item.row, i_item.col}] <= i_item.value;
        if (o_take && i_item.cmd == CMD_LOAD_B) r_mem_b[{i_item.row, i_item.col}] <= i_item.value;
        if (w_issue) begin
            r_rd_a <= r_mem_a[w_aa];
            r_rd_b <= r_mem_b[w_ba];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (o_take && i_item.cmd == CMD_COMPUTE) n_state = S_RUN;
            S_RUN:  n_state = S_ACC;
            S_ACC:  n_state = r_lastk ? S_OUT : S_RUN;
            S_OUT:  if (w_out_free) n_state = w_elem_last ? S_IDLE : S_RUN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_id     <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ovalid <= (r_ovalid && !i_pop) || ((r_state == S_OUT) && w_out_free);
            unique case (r_state)
                S_IDLE: begin
                    if (o_take && i_item.cmd == CMD_COMPUTE) begin
                        r_r   <= '0;
                        r_c   <= '0;
                        r_k   <= '0;
                        r_acc <= '0;
                        r_n1  <= IDX_W'(w_n - 1'b1);
                        r_mul <= i_mode;
                        r_id  <= 1'b1;
                    end
                end
                S_RUN: begin
                    r_lastk <= w_kend;
                    r_k <= r_k + 1'b1;
                end
                S_ACC: r_acc <= w_sum;
                S_OUT: begin
                    if (w_out_free) begin
                        r_out.row <= r_r;
                        r_out.col <= r_c;
                        r_out.value <= r_acc;
                        r_out.last <= w_elem_last;
                        r_out.is_identity <= w_elem_last && r_id && (r_acc == w_want);
                        if (r_acc != w_want) r_id <= 1'b0;
                        r_acc <= '0;
                        r_k <= '0;
                        if (r_c == r_n1) begin
                            r_c <= '0;
                            r_r <= r_r + 1'b1;
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_empty = !r_ovalid;
    assign o_res = r_out;
endmodule

// File: rtl/matrix_add_multiply_identity_check.sv
`timescale 1ns / 1ps
// Square matrix add/multiply with identity check. Loads (cmd 0/1) enter a
// four-entry queue at one item per cycle while it is not full; the back end
// takes a load only while idle. A compute emits n*n result items row by row;
// each element takes one run/accumulate step per MAC (n in multiply mode, one
// in add mode) on the shared multiply-accumulate, then an output step. The last
// item carries the identity flag. Results wait in a one-deep output register.
module matrix_add_multiply_identity_check import mami_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DIM_W-1:0]         i_cfg_data,
    input  logic                     push,
    output logic                     full,
    input  logic [1:0]               i_cmd,
    input  logic [IDX_W-1:0]         i_row,
    input  logic [IDX_W-1:0]         i_col,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     empty,
    input  logic                     pop,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic                     o_is_identity,
    output logic                     o_last
);
    logic [DIM_W-1:0] r_dim;
    logic             r_mode;
    t_item            w_in, w_q;
    t_result          w_res;
    logic             w_qv, w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim  <= DIM_W'(1);
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DIM) r_dim <= i_cfg_data;
            if (i_cfg_idx == CFG_MODE) r_mode <= i_cfg_data[0];
        end
    end

    assign w_in = '{cmd: i_cmd, row: i_row, col: i_col, value: i_value};

    mami_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(w_in), .o_valid(w_qv), .i_take(w_take), .o_item(w_q)
    );

    mami_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_dim(r_dim), .i_mode(r_mode),
        .i_valid(w_qv), .o_take(w_take), .i_item(w_q),
        .o_empty(empty), .i_pop(pop), .o_res(w_res)
    );

    assign o_out_row     = w_res.row;
    assign o_out_col     = w_res.col;
    assign o_out_value   = w_res.value;
    assign o_is_identity = w_res.is_identity;
    assign o_last        = w_res.last;

    a_id_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_identity) |-> o_last) else $error("identity flag off last item");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_value) && $stable(o_last)))
        else $error("result changed while waiting");
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_qv) else $error("take from empty queue");
endmodule

// File: verif/tb_matrix_add_multiply_identity_check.sv
`timescale 1ns / 1ps
module tb_matrix_add_multiply_identity_check import mami_pkg::*; ();

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              is_identity;
        logic              last;
    } t_elem;

    // Mirror of the matrix unit; predicts every element of a compute run.
    class matrix_scoreboard;
        logic [DATA_W-1:0] mat_a [DEPTH];
        logic [DATA_W-1:0] mat_b [DEPTH];
        int unsigned dim_reg;
        bit mul_mode;
        t_elem pending[$];
        int errors;
        int results_seen;

        function void clear();
            foreach (mat_a[i]) begin
                mat_a[i] = '0;
                mat_b[i] = '0;
            end
            dim_reg = 1;
            mul_mode = 0;
        endfunction

        function void set_reg(bit idx, logic [DIM_W-1:0] data);
            if (idx == CFG_DIM) dim_reg = int'(data);
            else mul_mode = data[0];
        endfunction

        function void note_item(logic [1:0] cmd, logic [2:0] r, logic [2:0] c,
                                logic [31:0] v);
            int unsigned n;
            logic [31:0] acc;
            bit ident;
            t_elem e;
            if (cmd == CMD_LOAD_A) mat_a[r*MAX_DIM+c] = v;
            else if (cmd == CMD_LOAD_B) mat_b[r*MAX_DIM+c] = v;
            else if (cmd == CMD_COMPUTE) begin
                n = (dim_reg == 0) ? 1 : (dim_reg > MAX_DIM) ? MAX_DIM : dim_reg;
                ident = 1;
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        if (!mul_mode) acc = mat_a[i*MAX_DIM+j] + mat_b[i*MAX_DIM+j];
                        else begin
                            acc = '0;
                            for (int k = 0; k < n; k++)
                                acc += mat_a[i*MAX_DIM+k] * mat_b[k*MAX_DIM+j];
                        end
                        if (acc != ((i == j) ? 32'd1 : 32'd0)) ident = 0;
                        e.row = IDX_W'(i);
                        e.col = IDX_W'(j);
                        e.value = acc;
                        e.last = (i == n-1) && (j == n-1);
                        e.is_identity = e.last && ident;
                        pending.push_back(e);
                    end
                end
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(t_elem got);
            t_elem w;
            results_seen++;
            if (pending.size() == 0) begin
                report("unexpected item", got.value, '0);
                return;
            end
            w = pending.pop_front();
            if (got.row !== w.row) report("row", 32'(got.row), 32'(w.row));
            if (got.col !== w.col) report("col", 32'(got.col), 32'(w.col));
            if (got.value !== w.value) report("value", got.value, w.value);
            if (got.is_identity !== w.is_identity)
                report("is_identity", 32'(got.is_identity), 32'(w.is_identity));
            if (got.last !== w.last) report("last", 32'(got.last), 32'(w.last));
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DIM_W-1:0] i_cfg_data = '0;
    logic push = 0;
    logic full;
    logic [1:0] i_cmd = '0;
    logic [IDX_W-1:0] i_row = '0, i_col = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic empty;
    logic pop = 0;
    logic [IDX_W-1:0] o_out_row, o_out_col;
    logic signed [DATA_W-1:0] o_out_value;
    logic o_is_identity, o_last;

    matrix_add_multiply_identity_check DUT (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    matrix_scoreboard sb = new();
    bit calm_tail = 0;
    int hold_cycles = 0;
    int computes = 0;

    // Receiver: random pop stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        t_elem g;
        if (i_rst_n && pop && !empty) begin
            g.row = o_out_row;
            g.col = o_out_col;
            g.value = o_out_value;
            g.is_identity = o_is_identity;
            g.last = o_last;
            sb.check_result(g);
        end
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 0;
            end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 17);
                pop <= 0;
                repeat (gap - 1) @(posedge i_clk);
            end else pop <= 1;
        end
    end

    // push stays high between back-to-back items; drain drops it
    task send_item(logic [1:0] cmd, logic [2:0] r, logic [2:0] c, logic [31:0] v);
        int gap;
        if (!calm_tail && $urandom_range(0, 11) == 0) begin
            gap = $urandom_range(1, 17);
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1;
        i_cmd <= cmd;
        i_row <= r;
        i_col <= c;
        i_value <= v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_item(cmd, r, c, v);
        if (cmd == CMD_COMPUTE) computes++;
    endtask

    task drain();
        push <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task write_reg(bit idx, logic [DIM_W-1:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    function logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    // Loads the whole 8x8 area of both matrices so any dimension is safe.
    task fill_all(bit ident_a, bit ident_b);
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++) begin
                send_item(CMD_LOAD_A, 3'(r), 3'(c),
                          ident_a ? ((r == c) ? 32'd1 : 32'd0) : rand_val());
                send_item(CMD_LOAD_B, 3'(r), 3'(c),
                          ident_b ? ((r == c) ? 32'd1 : 32'd0) : rand_val());
            end
    endtask

    int sent = 0;

    initial begin
        int d;
        sb.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: add/mult identity cases, dimension extremes, unused command
        send_item(CMD_LOAD_A, 3'd0, 3'd0, 32'd1);
        send_item(CMD_LOAD_B, 3'd0, 3'd0, 32'd0);
        send_item(CMD_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff);
        send_item(CMD_UNUSED, 3'd7, 3'd7, 32'h8000_0000);
        drain();
        fill_all(1, 1);
        drain();
        write_reg(CFG_MODE, DIM_W'(1));
        write_reg(CFG_DIM, DIM_W'(8));
        send_item(CMD_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain();
        write_reg(CFG_DIM, DIM_W'(0));
        send_item(CMD_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain();
        write_reg(CFG_DIM, DIM_W'(15));
        write_reg(CFG_MODE, DIM_W'(0));
        send_item(CMD_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain();

        // long hold-off while computes keep coming, so the input queue fills
        fill_all(0, 0);
        drain();
        write_reg(CFG_MODE, DIM_W'(1));
        write_reg(CFG_DIM, DIM_W'(2));
        hold_cycles = 200;
        repeat (8) send_item(CMD_COMPUTE, 3'd0, 3'd0, 32'd0);
        drain();

        // random: mixed loads, computes and unused commands, mostly small dimensions
        while (sent < 180) begin
            if (sent > 150) calm_tail = 1;
            if ($urandom_range(0, 19) == 0) begin
                drain();
                d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(1, 3);
                write_reg(CFG_DIM, DIM_W'(d));
                write_reg(CFG_MODE, DIM_W'($urandom_range(0, 1)));
            end
            case ($urandom_range(0, 9))
                0: send_item(CMD_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
                1: send_item(CMD_UNUSED, 3'($urandom), 3'($urandom), $urandom);
                2, 3: send_item(CMD_LOAD_A, 3'($urandom_range(0, 2)),
                                3'($urandom_range(0, 2)),
                                (($urandom_range(0, 1)) ? 32'd1 : 32'd0));
                default: send_item(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom),
                                   rand_val());
            endcase
            sent++;
        end
        drain();
        $display("covered %0d random items, %0d computes, %0d result items",
                 sent, computes, sb.results_seen);
        if (sb.errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
